>>> rtl/core/arp_pkg.sv
`default_nettype none
package arp_pkg;

   typedef enum logic [1:0] {
      K_NONE = 2'd0,
      K_DATA = 2'd1,
      K_MOVW = 2'd2,
      K_IMM  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_ABS  = 2'd1,
      OP_PREL = 2'd2,
      OP_PAGE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      E_26  = 3'd0,
      E_19  = 3'd1,
      E_16  = 3'd2,
      E_14  = 3'd3,
      E_12  = 3'd4,
      E_ADR = 3'd5
   } enc_type;

   typedef struct packed {
      logic     bad;
      kind_type kind;
      op_type   op;
      logic [5:0] lsb;
      logic [6:0] len;
      enc_type  enc;
      logic     chk;
      logic     nz;
   } plan_type;

   typedef struct packed {
      plan_type    plan;
      logic [63:0] x;
      logic [31:0] word;
   } mid_type;

   typedef struct packed {
      logic [63:0] new_contents;
      logic [1:0]  write_size;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] SZ_NONE = 2'd0;
   localparam logic [1:0] SZ_2    = 2'd1;
   localparam logic [1:0] SZ_4    = 2'd2;
   localparam logic [1:0] SZ_8    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNSUP = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;

   localparam logic [31:0] BRK_WORD = 32'hd420_2000;

endpackage
`default_nettype wire

>>> rtl/core/arp_fifo.sv
`default_nettype none
module arp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/arp_front.sv
`default_nettype none
module arp_front (
   input  wire logic [8:0]  command,
   input  wire logic [63:0] place_address,
   input  wire logic [63:0] target_value,
   input  wire logic [31:0] old_word,
   output arp_pkg::mid_type entry
);

   // P32 types
   localparam logic [8:0] P_ABS32 = 9'd1,  P_ABS16 = 9'd2,  P_PREL32 = 9'd3;
   localparam logic [8:0] P_PREL16 = 9'd4, P_UABS_G0 = 9'd5, P_UABS_G0_NC = 9'd6;
   localparam logic [8:0] P_UABS_G1 = 9'd7, P_SABS_G0 = 9'd8, P_PREL_G0 = 9'd9;
   localparam logic [8:0] P_PREL_G0_NC = 9'd10, P_PREL_G1 = 9'd11;
   localparam logic [8:0] P_LD_LO19 = 9'd12, P_ADR_LO21 = 9'd13, P_ADR_HI21 = 9'd14;
   localparam logic [8:0] P_ADD_LO12 = 9'd15, P_LDST8 = 9'd16, P_LDST16 = 9'd17;
   localparam logic [8:0] P_LDST32 = 9'd18, P_LDST64 = 9'd19, P_LDST128 = 9'd20;
   localparam logic [8:0] P_TSTBR14 = 9'd21, P_CONDBR19 = 9'd22;
   localparam logic [8:0] P_JUMP26 = 9'd23, P_CALL26 = 9'd24;
   // LP64 types
   localparam logic [8:0] R_NULL = 9'd0, R_NONE = 9'd256, R_ABS64 = 9'd257;
   localparam logic [8:0] R_ABS32 = 9'd258, R_ABS16 = 9'd259, R_PREL64 = 9'd260;
   localparam logic [8:0] R_PREL32 = 9'd261, R_PREL16 = 9'd262;
   localparam logic [8:0] R_UABS_G0 = 9'd263, R_UABS_G0_NC = 9'd264;
   localparam logic [8:0] R_UABS_G1 = 9'd265, R_UABS_G1_NC = 9'd266;
   localparam logic [8:0] R_UABS_G2 = 9'd267, R_UABS_G2_NC = 9'd268;
   localparam logic [8:0] R_UABS_G3 = 9'd269, R_SABS_G0 = 9'd270;
   localparam logic [8:0] R_SABS_G1 = 9'd271, R_SABS_G2 = 9'd272;
   localparam logic [8:0] R_LD_LO19 = 9'd273, R_ADR_LO21 = 9'd274;
   localparam logic [8:0] R_ADR_HI21 = 9'd275, R_ADR_HI21_NC = 9'd276;
   localparam logic [8:0] R_ADD_LO12 = 9'd277, R_LDST8 = 9'd278;
   localparam logic [8:0] R_TSTBR14 = 9'd279, R_CONDBR19 = 9'd280;
   localparam logic [8:0] R_JUMP26 = 9'd282, R_CALL26 = 9'd283;
   localparam logic [8:0] R_LDST16 = 9'd284, R_LDST32 = 9'd285, R_LDST64 = 9'd286;
   localparam logic [8:0] R_PREL_G0 = 9'd287, R_PREL_G0_NC = 9'd288;
   localparam logic [8:0] R_PREL_G1 = 9'd289, R_PREL_G1_NC = 9'd290;
   localparam logic [8:0] R_PREL_G2 = 9'd291, R_PREL_G2_NC = 9'd292;
   localparam logic [8:0] R_PREL_G3 = 9'd293, R_LDST128 = 9'd299;

   function automatic arp_pkg::plan_type mk(
      arp_pkg::kind_type kind, arp_pkg::op_type op, logic [5:0] lsb,
      logic [6:0] len, arp_pkg::enc_type enc, int chk, int nz);
      arp_pkg::plan_type p;
      p.bad  = 1'b0;
      p.kind = kind;
      p.op   = op;
      p.lsb  = lsb;
      p.len  = len;
      p.enc  = enc;
      p.chk  = chk[0];
      p.nz   = nz[0];
      return p;
   endfunction

   arp_pkg::plan_type plan;
   logic [63:0] pa_page, tv_page;

   always_comb begin
      case (command)
         R_NULL, R_NONE:
            plan = mk(arp_pkg::K_NONE, arp_pkg::OP_NONE, 6'd0, 7'd0, arp_pkg::E_26, 0, 0);
         R_ABS64:
            plan = mk(arp_pkg::K_DATA, arp_pkg::OP_ABS, 6'd0, 7'd64, arp_pkg::E_26, 0, 0);
         P_ABS32, R_ABS32:
            plan = mk(arp_pkg::K_DATA, arp_pkg::OP_ABS, 6'd0, 7'd32, arp_pkg::E_26, 1, 0);
         P_ABS16, R_ABS16:
            plan = mk(arp_pkg::K_DATA, arp_pkg::OP_ABS, 6'd0, 7'd16, arp_pkg::E_26, 1, 0);
         R_PREL64:
            plan = mk(arp_pkg::K_DATA, arp_pkg::OP_PREL, 6'd0, 7'd64, arp_pkg::E_26, 0, 0);
         P_PREL32, R_PREL32:
            plan = mk(arp_pkg::K_DATA, arp_pkg::OP_PREL, 6'd0, 7'd32, arp_pkg::E_26, 1, 0);
         P_PREL16, R_PREL16:
            plan = mk(arp_pkg::K_DATA, arp_pkg::OP_PREL, 6'd0, 7'd16, arp_pkg::E_26, 1, 0);
         P_UABS_G0_NC, R_UABS_G0_NC:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd0, 7'd0, arp_pkg::E_16, 0, 0);
         P_UABS_G0, R_UABS_G0:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd0, 7'd0, arp_pkg::E_16, 1, 0);
         R_UABS_G1_NC:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd16, 7'd0, arp_pkg::E_16, 0, 0);
         P_UABS_G1, R_UABS_G1:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd16, 7'd0, arp_pkg::E_16, 1, 0);
         R_UABS_G2_NC:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd32, 7'd0, arp_pkg::E_16, 0, 0);
         R_UABS_G2:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd32, 7'd0, arp_pkg::E_16, 1, 0);
         R_UABS_G3:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd48, 7'd0, arp_pkg::E_16, 0, 0);
         P_SABS_G0, R_SABS_G0:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd0, 7'd0, arp_pkg::E_16, 1, 1);
         R_SABS_G1:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd16, 7'd0, arp_pkg::E_16, 1, 1);
         R_SABS_G2:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_ABS, 6'd32, 7'd0, arp_pkg::E_16, 1, 1);
         P_PREL_G0_NC, R_PREL_G0_NC:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_PREL, 6'd0, 7'd0, arp_pkg::E_16, 0, 0);
         P_PREL_G0, R_PREL_G0:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_PREL, 6'd0, 7'd0, arp_pkg::E_16, 1, 1);
         R_PREL_G1_NC:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_PREL, 6'd16, 7'd0, arp_pkg::E_16, 0, 0);
         P_PREL_G1, R_PREL_G1:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_PREL, 6'd16, 7'd0, arp_pkg::E_16, 1, 1);
         R_PREL_G2_NC:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_PREL, 6'd32, 7'd0, arp_pkg::E_16, 0, 0);
         R_PREL_G2:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_PREL, 6'd32, 7'd0, arp_pkg::E_16, 1, 1);
         R_PREL_G3:
            plan = mk(arp_pkg::K_MOVW, arp_pkg::OP_PREL, 6'd48, 7'd0, arp_pkg::E_16, 0, 1);
         P_LD_LO19, R_LD_LO19, P_CONDBR19, R_CONDBR19:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_PREL, 6'd2, 7'd19, arp_pkg::E_19, 1, 0);
         P_ADR_LO21, R_ADR_LO21:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_PREL, 6'd0, 7'd21, arp_pkg::E_ADR, 1, 0);
         R_ADR_HI21_NC:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_PAGE, 6'd12, 7'd21, arp_pkg::E_ADR, 0, 0);
         P_ADR_HI21, R_ADR_HI21:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_PAGE, 6'd12, 7'd21, arp_pkg::E_ADR, 1, 0);
         P_ADD_LO12, P_LDST8, R_ADD_LO12, R_LDST8:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_ABS, 6'd0, 7'd12, arp_pkg::E_12, 0, 0);
         P_LDST16, R_LDST16:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_ABS, 6'd1, 7'd11, arp_pkg::E_12, 0, 0);
         P_LDST32, R_LDST32:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_ABS, 6'd2, 7'd10, arp_pkg::E_12, 0, 0);
         P_LDST64, R_LDST64:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_ABS, 6'd3, 7'd9, arp_pkg::E_12, 0, 0);
         P_LDST128, R_LDST128:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_ABS, 6'd4, 7'd8, arp_pkg::E_12, 0, 0);
         P_TSTBR14, R_TSTBR14:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_PREL, 6'd2, 7'd14, arp_pkg::E_14, 1, 0);
         P_JUMP26, P_CALL26, R_JUMP26, R_CALL26:
            plan = mk(arp_pkg::K_IMM, arp_pkg::OP_PREL, 6'd2, 7'd26, arp_pkg::E_26, 1, 0);
         default: begin
            plan = mk(arp_pkg::K_NONE, arp_pkg::OP_NONE, 6'd0, 7'd0, arp_pkg::E_26, 0, 0);
            plan.bad = 1'b1;
         end
      endcase
   end

   assign pa_page = {place_address[63:12], 12'h000};
   assign tv_page = {target_value[63:12], 12'h000};

   always_comb begin
      entry.plan = plan;
      entry.word = old_word;
      case (plan.op)
         arp_pkg::OP_PREL: entry.x = target_value - place_address;
         arp_pkg::OP_PAGE: entry.x = tv_page - pa_page;
         default:          entry.x = target_value;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/arp_back.sv
`default_nettype none
module arp_back (
   input  wire arp_pkg::mid_type entry,
   output arp_pkg::rsp_type      rsp
);

   // true when v is the sign extension of its low 'bits' bits
   function automatic logic fits_f(logic [63:0] v, logic [6:0] bits);
      logic [63:0] hi;
      logic [63:0] ones;
      ones = '1;
      hi   = ones << (bits - 7'd1);
      return ((v & hi) == '0) || ((v & hi) == hi);
   endfunction

   function automatic logic [31:0] insert_f(arp_pkg::enc_type enc, logic [31:0] w,
                                             logic [63:0] f);
      logic [31:0] r;
      r = w;
      if (w != arp_pkg::BRK_WORD) begin
         case (enc)
            arp_pkg::E_26: r[25:0]  = f[25:0];
            arp_pkg::E_19: r[23:5]  = f[18:0];
            arp_pkg::E_16: r[20:5]  = f[15:0];
            arp_pkg::E_14: r[18:5]  = f[13:0];
            arp_pkg::E_12: r[21:10] = f[11:0];
            default: begin
               r[30:29] = f[1:0];
               r[23:5]  = f[20:2];
            end
         endcase
      end
      return r;
   endfunction

   arp_pkg::plan_type p;
   logic [63:0] xs, imm, lo_mask, ones;
   logic [31:0] w;
   logic        ovf;

   assign p    = entry.plan;
   assign ones = '1;
   assign xs   = 64'($signed(entry.x) >>> p.lsb);
   assign lo_mask = ~(ones << p.len);

   always_comb begin
      rsp.new_contents = '0;
      rsp.write_size   = arp_pkg::SZ_NONE;
      rsp.status       = arp_pkg::ST_OK;
      ovf = 1'b0;
      imm = xs;
      w   = entry.word;
      case (p.kind)
         arp_pkg::K_DATA: begin
            if (p.len == 7'd64) begin
               rsp.new_contents = entry.x;
               rsp.write_size   = arp_pkg::SZ_8;
            end else if (p.len == 7'd32) begin
               rsp.new_contents = {32'h0, entry.x[31:0]};
               rsp.write_size   = arp_pkg::SZ_4;
               ovf = (p.op == arp_pkg::OP_ABS) ? (entry.x[63:32] != '0)
                                               : !fits_f(entry.x, 7'd32);
            end else begin
               rsp.new_contents = {48'h0, entry.x[15:0]};
               rsp.write_size   = arp_pkg::SZ_2;
               ovf = (p.op == arp_pkg::OP_ABS) ? (entry.x[63:16] != '0)
                                               : !fits_f(entry.x, 7'd16);
            end
         end
         arp_pkg::K_MOVW: begin
            if (p.nz) begin
               w[30:29] = entry.x[63] ? 2'b00 : 2'b10;
               imm = entry.x[63] ? ~xs : xs;
            end
            w   = insert_f(arp_pkg::E_16, w, imm);
            ovf = (imm[63:16] != '0);
            rsp.new_contents = {32'h0, w};
            rsp.write_size   = arp_pkg::SZ_4;
         end
         arp_pkg::K_IMM: begin
            w   = insert_f(p.enc, w, xs & lo_mask);
            ovf = !fits_f(xs, p.len);
            rsp.new_contents = {32'h0, w};
            rsp.write_size   = arp_pkg::SZ_4;
         end
         default: begin
            rsp.new_contents = '0;
         end
      endcase
      if (p.bad) begin
         rsp.status = arp_pkg::ST_UNSUP;
      end else if (p.chk && ovf) begin
         rsp.status = arp_pkg::ST_OVF;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/aarch64_relocation_patcher_core.sv
// AArch64 ELF RELA relocation patcher. Each word pushed on the req_ side is
// one relocation (type code, place address, S+A, old instruction word); each
// word popped on the rsp_ side is the patched contents, write size and status
// for it, in order. One relocation is accepted per clock while the request
// queue has room; a request passes through the front-to-back queue and then
// the output queue before its result can be popped. The front stage decodes
// the type and forms the 64-bit absolute, PC-relative or page-relative value;
// the back stage shifts, inserts the immediate and checks range. Two queues of
// QUEUE_DEPTH words each (front to back, back to output) let either side stall without losing a relocation.
`default_nettype none
module aarch64_relocation_patcher_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [8:0]  req_command,
   input  wire logic [63:0] req_place_address,
   input  wire logic [63:0] req_target_value,
   input  wire logic [31:0] req_old_word,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [63:0]      rsp_new_contents,
   output logic [1:0]       rsp_write_size,
   output logic [1:0]       rsp_status
);

   localparam int MID_W = $bits(arp_pkg::mid_type);
   localparam int RSP_W = $bits(arp_pkg::rsp_type);

   arp_pkg::mid_type front_entry, back_entry;
   arp_pkg::rsp_type back_rsp, out_rsp;
   logic [MID_W-1:0] mid_rdata;
   logic [RSP_W-1:0] out_rdata;
   logic mid_empty, out_full, back_fire;

   arp_front u_front (
      .command       (req_command),
      .place_address (req_place_address),
      .target_value  (req_target_value),
      .old_word      (req_old_word),
      .entry         (front_entry)
   );

   arp_fifo #(.WIDTH(MID_W), .DEPTH(QUEUE_DEPTH)) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_entry),
      .full  (req_full),
      .pop   (back_fire),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   assign back_entry = arp_pkg::mid_type'(mid_rdata);
   assign back_fire  = !mid_empty && !out_full;

   arp_back u_back (
      .entry (back_entry),
      .rsp   (back_rsp)
   );

   arp_fifo #(.WIDTH(RSP_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (back_fire),
      .wdata (back_rsp),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign out_rsp          = arp_pkg::rsp_type'(out_rdata);
   assign rsp_new_contents = out_rsp.new_contents;
   assign rsp_write_size   = out_rsp.write_size;
   assign rsp_status       = out_rsp.status;

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> !mid_empty)
      else $error("accepted request missing from queue");

   a_back_drains: assert property (@(posedge clock) disable iff (reset)
      (!mid_empty && !out_full) |=> !rsp_empty)
      else $error("processed word missing from output queue");

   a_unsup_no_write: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == arp_pkg::ST_UNSUP) |->
      (rsp_write_size == arp_pkg::SZ_NONE && rsp_new_contents == '0))
      else $error("unsupported type produced a write");

   a_ovf_has_write: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == arp_pkg::ST_OVF) |->
      (rsp_write_size != arp_pkg::SZ_NONE))
      else $error("overflow reported without contents");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (mid_empty && rsp_empty && !req_push) |=> rsp_empty)
      else $error("result appeared with nothing queued");

endmodule
`default_nettype wire
